FILE: rtl/flrx_pkg.sv
// ----------------------------------------------------------------------------
// flrx_pkg
// Shared types, constants and functions of the framed link receiver.
// ----------------------------------------------------------------------------
package flrx_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int PAY_AW      = $clog2(MAX_PAYLOAD);
  localparam int PAY_CW      = PAY_AW + 1;

  localparam logic [PAY_CW-1:0] MAX_PAYLOAD_C = PAY_CW'(MAX_PAYLOAD);

  localparam logic [7:0] START_BYTE = 8'hAA;
  localparam logic [7:0] CRC_POLY   = 8'h07;

  localparam logic [7:0] TYPE_BYTE  = 8'h01;
  localparam logic [7:0] TYPE_WORD  = 8'h02;
  localparam logic [7:0] TYPE_FLOAT = 8'h03;
  localparam logic [7:0] TYPE_DATA  = 8'h04;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_MAX_LEN = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd50;
  localparam logic [6:0]  MAX_LEN_RESET = 7'd64;

  localparam logic [1:0] HDR_TYPE   = 2'd0;
  localparam logic [1:0] HDR_SEQ    = 2'd1;
  localparam logic [1:0] HDR_LEN_HI = 2'd2;
  localparam logic [1:0] HDR_LEN_LO = 2'd3;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_HEADER  = 7'b0000010,
    S_PAYLOAD = 7'b0000100,
    S_CRC     = 7'b0001000,
    S_DISCARD = 7'b0010000,
    S_DRD     = 7'b0100000,
    S_DEMIT   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic hdr_clear;
    logic hdr_load;
    logic pay_write;
    logic tick_inc;
    logic tick_clr;
    logic seq_commit;
    logic drain_start;
    logic drain_next;
    logic emit_nack;
    logic emit_ack;
    logic emit_drain;
    logic draining;
  } cmd_t;

  typedef struct packed {
    logic start_hit;
    logic hdr_last;
    logic len_ok;
    logic pay_last;
    logic crc_ok;
    logic dup;
    logic timeout;
    logic drain_last;
    logic out_free;
  } status_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic length_ok(input logic [7:0] ftype, input logic [15:0] len,
                                     input logic [6:0] max_len);
    logic ok;
    case (ftype)
      TYPE_BYTE:  ok = (len == 16'd1);
      TYPE_WORD:  ok = (len == 16'd2);
      TYPE_FLOAT: ok = (len == 16'd4);
      TYPE_DATA:  ok = (len >= 16'd1) && (len <= {9'd0, max_len})
                       && (len <= 16'(MAX_PAYLOAD));
      default:    ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

FILE: rtl/flrx_ctrl.sv
// ----------------------------------------------------------------------------
// flrx_ctrl
// Frame receiver controller: protocol phases, timeouts and payload release.
// ----------------------------------------------------------------------------
module flrx_ctrl
  import flrx_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_command,
  input  status_t status,
  output logic    in_ready,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   fire;

  assign in_ready = !(state == S_DRD || state == S_DEMIT) && status.out_free;
  assign fire     = in_valid && in_ready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.draining = (state == S_DRD) || (state == S_DEMIT);
    case (state)
      S_IDLE: begin
        if (fire && in_command == CMD_BYTE && status.start_hit) begin
          cmd.hdr_clear = 1'b1;
          state_next    = S_HEADER;
        end
      end
      S_HEADER, S_PAYLOAD, S_CRC, S_DISCARD: begin
        if (fire && in_command == CMD_TICK) begin
          cmd.tick_inc = 1'b1;
          if (status.timeout) begin
            if (state != S_DISCARD) begin
              cmd.tick_clr = 1'b1;
              state_next   = S_DISCARD;
            end else begin
              cmd.emit_nack = 1'b1;
              state_next    = S_IDLE;
            end
          end
        end else if (fire) begin
          cmd.tick_clr = 1'b1;
          case (state)
            S_HEADER: begin
              cmd.hdr_load = 1'b1;
              if (status.hdr_last) begin
                state_next = status.len_ok ? S_PAYLOAD : S_DISCARD;
              end
            end
            S_PAYLOAD: begin
              cmd.pay_write = 1'b1;
              if (status.pay_last) begin
                state_next = S_CRC;
              end
            end
            S_CRC: begin
              if (!status.crc_ok) begin
                state_next = S_DISCARD;
              end else if (status.dup) begin
                cmd.emit_ack = 1'b1;
                state_next   = S_IDLE;
              end else begin
                cmd.seq_commit  = 1'b1;
                cmd.drain_start = 1'b1;
                state_next      = S_DRD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DRD: begin
        state_next = S_DEMIT;
      end
      S_DEMIT: begin
        if (status.out_free) begin
          cmd.emit_drain = 1'b1;
          if (status.drain_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.drain_next = 1'b1;
            state_next     = S_DRD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/flrx_dp.sv
// ----------------------------------------------------------------------------
// flrx_dp
// Frame receiver datapath: header fields, CRC, tick counter, payload buffer
// and the output register.
// ----------------------------------------------------------------------------
module flrx_dp
  import flrx_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_addr,
  input  logic [15:0]   cfg_data,
  input  logic [7:0]    rx_byte,
  input  cmd_t          cmd,
  output status_t       status,
  input  logic          out_ready,
  output logic          out_valid,
  output logic          reply_valid,
  output logic          reply_is_ack,
  output logic [7:0]    reply_seq,
  output logic          payload_valid,
  output logic [7:0]    payload_byte,
  output logic [2:0]    frame_kind,
  output logic          out_last
);

  logic [15:0]       timeout_ticks;
  logic [6:0]        max_data_len;
  logic [1:0]        header_index;
  logic [7:0]        frame_type;
  logic [7:0]        frame_seq;
  logic [15:0]       frame_length;
  logic [PAY_CW-1:0] payload_count;
  logic [7:0]        crc_accum;
  logic [15:0]       tick_counter;
  logic [7:0]        last_seq;
  logic              last_seq_valid;
  logic [PAY_AW-1:0] drain_idx;
  logic [7:0]        mem [MAX_PAYLOAD];
  logic [7:0]        rdata;

  logic [15:0]       tick_inc;
  logic [PAY_CW-1:0] count_inc;
  logic [7:0]        crc_next;
  logic              first;

  assign tick_inc  = (tick_counter == 16'hFFFF) ? tick_counter : tick_counter + 16'd1;
  assign count_inc = payload_count + PAY_CW'(1);
  assign crc_next  = crc8_update(crc_accum, rx_byte);
  assign first     = (drain_idx == '0);

  always_comb begin
    status            = '0;
    status.start_hit  = (rx_byte == START_BYTE);
    status.hdr_last   = (header_index == HDR_LEN_LO);
    status.len_ok     = length_ok(frame_type, {frame_length[15:8], rx_byte}, max_data_len);
    status.pay_last   = ({{(16-PAY_CW){1'b0}}, count_inc} >= frame_length)
                        || (count_inc >= MAX_PAYLOAD_C);
    status.crc_ok     = (rx_byte == crc_accum);
    status.dup        = last_seq_valid && (frame_seq == last_seq);
    status.timeout    = (tick_inc >= timeout_ticks);
    status.drain_last = ({1'b0, drain_idx} + PAY_CW'(1) == payload_count);
    status.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      max_data_len  <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TIMEOUT: timeout_ticks <= cfg_data;
        REG_MAX_LEN: max_data_len  <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_index   <= '0;
      frame_type     <= '0;
      frame_seq      <= '0;
      frame_length   <= '0;
      payload_count  <= '0;
      crc_accum      <= '0;
      tick_counter   <= '0;
      last_seq       <= '0;
      last_seq_valid <= 1'b0;
      drain_idx      <= '0;
    end else begin
      if (cmd.hdr_clear) begin
        header_index  <= '0;
        frame_type    <= '0;
        frame_seq     <= '0;
        frame_length  <= '0;
        payload_count <= '0;
        crc_accum     <= '0;
      end
      if (cmd.hdr_load) begin
        crc_accum    <= crc_next;
        header_index <= header_index + 2'd1;
        case (header_index)
          HDR_TYPE:   frame_type   <= rx_byte;
          HDR_SEQ:    frame_seq    <= rx_byte;
          HDR_LEN_HI: frame_length <= {rx_byte, 8'd0};
          HDR_LEN_LO: begin
            frame_length  <= {frame_length[15:8], rx_byte};
            payload_count <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.pay_write) begin
        crc_accum     <= crc_next;
        payload_count <= count_inc;
      end
      if (cmd.tick_clr || cmd.hdr_clear) begin
        tick_counter <= '0;
      end else if (cmd.tick_inc) begin
        tick_counter <= tick_inc;
      end
      if (cmd.seq_commit) begin
        last_seq       <= frame_seq;
        last_seq_valid <= 1'b1;
      end
      if (cmd.drain_start) begin
        drain_idx <= '0;
      end else if (cmd.drain_next) begin
        drain_idx <= drain_idx + PAY_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pay_write) begin
      mem[payload_count[PAY_AW-1:0]] <= rx_byte;
    end
    rdata <= mem[drain_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_nack || cmd.emit_ack || cmd.emit_drain) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_nack || cmd.emit_ack) begin
      reply_valid   <= 1'b1;
      reply_is_ack  <= cmd.emit_ack;
      reply_seq     <= frame_seq;
      payload_valid <= 1'b0;
      payload_byte  <= '0;
      frame_kind    <= '0;
      out_last      <= 1'b1;
    end else if (cmd.emit_drain) begin
      reply_valid   <= first;
      reply_is_ack  <= first;
      reply_seq     <= first ? frame_seq : 8'd0;
      payload_valid <= 1'b1;
      payload_byte  <= rdata;
      frame_kind    <= frame_type[2:0];
      out_last      <= status.drain_last;
    end
  end

endmodule

FILE: rtl/framed_link_receiver_crc8_ack.sv
// ----------------------------------------------------------------------------
// framed_link_receiver_crc8_ack
// Stop-and-wait frame receiver with CRC-8 check and ACK/NACK replies.
// ----------------------------------------------------------------------------
// Each input transfer carries one link byte or one millisecond tick and is
// taken while the output register is free. A good frame with a new sequence
// then releases its n buffered payload bytes one result at a time, each
// through a read state and an emit state (registered payload buffer read),
// during which no input is taken; the first of these carries the ACK. A
// repeated frame gives one ACK-only result, a line-silence timeout after a
// bad frame one NACK result.
// ----------------------------------------------------------------------------
module framed_link_receiver_crc8_ack
  import flrx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic        s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // reply_valid, reply_is_ack, reply_seq[7:0],
                                      // payload_valid, payload_byte[7:0], zero pad
  output logic [2:0]  m_axis_tuser,   // frame_kind
  output logic        m_axis_tlast    // last
);

  cmd_t       cmd;
  status_t    status;
  logic       reply_valid;
  logic       reply_is_ack;
  logic [7:0] reply_seq;
  logic       payload_valid;
  logic [7:0] payload_byte;

  flrx_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_command (s_axis_tuser),
    .status     (status),
    .in_ready   (s_axis_tready),
    .cmd        (cmd)
  );

  flrx_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .rx_byte       (s_axis_tdata),
    .cmd           (cmd),
    .status        (status),
    .out_ready     (m_axis_tready),
    .out_valid     (m_axis_tvalid),
    .reply_valid   (reply_valid),
    .reply_is_ack  (reply_is_ack),
    .reply_seq     (reply_seq),
    .payload_valid (payload_valid),
    .payload_byte  (payload_byte),
    .frame_kind    (m_axis_tuser),
    .out_last      (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, payload_byte, payload_valid, reply_seq, reply_is_ack,
                         reply_valid};

  a_no_input_while_draining : assert property (@(posedge clk) disable iff (rst)
    cmd.draining |-> !s_axis_tready)
    else $error("input taken while payload drains");

  a_single_emit : assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.emit_nack, cmd.emit_ack, cmd.emit_drain}))
    else $error("more than one result loaded at once");

  a_emit_into_free_slot : assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_nack || cmd.emit_ack || cmd.emit_drain) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over a pending transfer");

endmodule

FILE: verif/framed_link_receiver_crc8_ack_tb.sv
// ----------------------------------------------------------------------------
// framed_link_receiver_crc8_ack_tb
// Self-checking bench for the CRC-8 framed link receiver with ACK/NACK.
// ----------------------------------------------------------------------------
// Link bytes and millisecond ticks are sent over the input stream. A
// behavioural model of the receiver, kept inside the bench, works out the
// replies and payload bytes due for each transfer. Every output transfer is
// compared field by field with the oldest reply still awaited. A short
// table of directed transfers comes first. Random frames follow in three
// register settings: good, repeated, corrupted, cut-short and header-fault
// frames mixed with line noise. Either side of the stream stalls at random,
// and once the output is held off long enough to stall the input.
// ----------------------------------------------------------------------------
module framed_link_receiver_crc8_ack_tb
  import flrx_pkg::*;
;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_CYCLES = 12;

  typedef enum logic [4:0] {
    LS_IDLE    = 5'b00001,
    LS_HEADER  = 5'b00010,
    LS_PAYLOAD = 5'b00100,
    LS_CRC     = 5'b01000,
    LS_DISCARD = 5'b10000
  } link_phase_t;

  typedef struct packed {
    logic       rv;
    logic       ack;
    logic [7:0] seq;
    logic       pv;
    logic [7:0] pb;
    logic [2:0] kind;
    logic       last;
  } reply_t;

  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_TICK,
    ROW_CRC
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] data;
    logic       typed;
    reply_t     want;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [29] = '{
    '{ROW_TICK, 8'hFF,       1'b0, '0},
    '{ROW_BYTE, 8'h55,       1'b0, '0},
    '{ROW_BYTE, START_BYTE,  1'b0, '0},
    '{ROW_TICK, 8'h00,       1'b0, '0},
    '{ROW_TICK, 8'h00,       1'b0, '0},
    '{ROW_TICK, 8'h00,       1'b0, '0},
    '{ROW_TICK, 8'h00,       1'b1, '{1'b1, 1'b0, 8'h00, 1'b0, 8'h00, 3'd0, 1'b1}},
    '{ROW_BYTE, START_BYTE,  1'b0, '0},
    '{ROW_BYTE, TYPE_BYTE,   1'b0, '0},
    '{ROW_BYTE, 8'h5A,       1'b0, '0},
    '{ROW_BYTE, 8'h00,       1'b0, '0},
    '{ROW_BYTE, 8'h01,       1'b0, '0},
    '{ROW_BYTE, 8'hFF,       1'b0, '0},
    '{ROW_CRC,  8'h00,       1'b1,
      '{1'b1, 1'b1, 8'h5A, 1'b1, 8'hFF, 3'(TYPE_BYTE), 1'b1}},
    '{ROW_BYTE, START_BYTE,  1'b0, '0},
    '{ROW_BYTE, TYPE_BYTE,   1'b0, '0},
    '{ROW_BYTE, 8'h5A,       1'b0, '0},
    '{ROW_BYTE, 8'h00,       1'b0, '0},
    '{ROW_BYTE, 8'h01,       1'b0, '0},
    '{ROW_BYTE, 8'hFF,       1'b0, '0},
    '{ROW_CRC,  8'h00,       1'b1, '{1'b1, 1'b1, 8'h5A, 1'b0, 8'h00, 3'd0, 1'b1}},
    '{ROW_BYTE, START_BYTE,  1'b0, '0},
    '{ROW_BYTE, TYPE_DATA,   1'b0, '0},
    '{ROW_BYTE, 8'hC3,       1'b0, '0},
    '{ROW_BYTE, 8'h00,       1'b0, '0},
    '{ROW_BYTE, 8'h41,       1'b0, '0},
    '{ROW_BYTE, 8'h00,       1'b0, '0},
    '{ROW_TICK, 8'h7E,       1'b0, '0},
    '{ROW_TICK, 8'h81,       1'b1, '{1'b1, 1'b0, 8'hC3, 1'b0, 8'h00, 3'd0, 1'b1}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  framed_link_receiver_crc8_ack uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // model state of the receiver
  logic [15:0]       pr_timeout = TIMEOUT_RESET;
  logic [6:0]        pr_max_len = MAX_LEN_RESET;
  link_phase_t       pr_phase = LS_IDLE;
  logic [1:0]        pr_hdr_idx = HDR_TYPE;
  logic [7:0]        pr_type = '0;
  logic [7:0]        pr_seq = '0;
  logic [15:0]       pr_len = '0;
  logic [PAY_CW-1:0] pr_count = '0;
  logic [7:0]        pr_crc = '0;
  logic [15:0]       pr_ticks = '0;
  logic [7:0]        pr_buf [MAX_PAYLOAD];
  logic [7:0]        pr_last_seq = '0;
  logic              pr_seen = 1'b0;

  reply_t step_replies [$];
  reply_t awaited_replies [$];

  int  live_items = 0;
  int  mismatch_count = 0;
  int  cycle_count;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  pressure_go = 1'b0;
  logic hold_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic reply_t reply_of(input logic rv, input logic ack, input logic [7:0] seq,
                                      input logic pv, input logic [7:0] pb,
                                      input logic [2:0] kind, input logic last);
    reply_t r;
    r.rv   = rv;
    r.ack  = ack;
    r.seq  = seq;
    r.pv   = pv;
    r.pb   = pb;
    r.kind = kind;
    r.last = last;
    return r;
  endfunction

  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    int i;
    c = acc ^ b;
    for (i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic bit length_fits(input logic [7:0] ftype, input logic [15:0] flen);
    case (ftype)
      TYPE_BYTE:  return flen == 16'd1;
      TYPE_WORD:  return flen == 16'd2;
      TYPE_FLOAT: return flen == 16'd4;
      TYPE_DATA:  return flen >= 16'd1 && flen <= {9'd0, pr_max_len} && flen <= MAX_PAYLOAD;
      default:    return 1'b0;
    endcase
  endfunction

  task automatic predict_link(input logic cmd, input logic [7:0] b);
    int n;
    int k;
    step_replies.delete();
    if (cmd == CMD_TICK) begin
      if (pr_phase == LS_IDLE) return;
      live_items++;
      if (pr_ticks != 16'hFFFF) pr_ticks++;
      if (pr_ticks < pr_timeout) return;
      if (pr_phase != LS_DISCARD) begin
        pr_phase = LS_DISCARD;
        pr_ticks = '0;
        return;
      end
      pr_phase = LS_IDLE;
      step_replies.push_back(reply_of(1'b1, 1'b0, pr_seq, 1'b0, 8'h00, 3'd0, 1'b1));
      return;
    end
    if (pr_phase == LS_IDLE && b != START_BYTE) return;
    live_items++;
    pr_ticks = '0;
    case (pr_phase)
      LS_IDLE: begin
        pr_phase   = LS_HEADER;
        pr_hdr_idx = HDR_TYPE;
        pr_type    = '0;
        pr_seq     = '0;
        pr_len     = '0;
        pr_count   = '0;
        pr_crc     = '0;
      end
      LS_HEADER: begin
        pr_crc = crc8_next(pr_crc, b);
        case (pr_hdr_idx)
          HDR_TYPE:   pr_type = b;
          HDR_SEQ:    pr_seq = b;
          HDR_LEN_HI: pr_len = {b, 8'h00};
          default: begin
            pr_len = {pr_len[15:8], b};
            if (length_fits(pr_type, pr_len)) begin
              pr_phase = LS_PAYLOAD;
              pr_count = '0;
            end else begin
              pr_phase = LS_DISCARD;
            end
          end
        endcase
        pr_hdr_idx = pr_hdr_idx + 2'd1;
      end
      LS_PAYLOAD: begin
        pr_crc = crc8_next(pr_crc, b);
        pr_buf[pr_count[PAY_AW-1:0]] = b;
        pr_count++;
        if (pr_count >= pr_len || pr_count >= MAX_PAYLOAD) pr_phase = LS_CRC;
      end
      LS_CRC: begin
        if (b != pr_crc) begin
          pr_phase = LS_DISCARD;
        end else begin
          pr_phase = LS_IDLE;
          if (pr_seen && pr_seq == pr_last_seq) begin
            step_replies.push_back(reply_of(1'b1, 1'b1, pr_seq, 1'b0, 8'h00, 3'd0, 1'b1));
          end else begin
            pr_last_seq = pr_seq;
            pr_seen     = 1'b1;
            n = (pr_count > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(pr_count);
            if (n < 1) begin
              step_replies.push_back(reply_of(1'b1, 1'b1, pr_seq, 1'b0, 8'h00, 3'd0, 1'b1));
            end
            for (k = 0; k < n; k++) begin
              step_replies.push_back(reply_of(k == 0, k == 0, (k == 0) ? pr_seq : 8'h00,
                                              1'b1, pr_buf[k], pr_type[2:0], k == n - 1));
            end
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("tb: mismatch %s got %0h want %0h", what, got, want);
    mismatch_count++;
  endtask

  task automatic check_reply();
    reply_t got;
    reply_t want;
    got = reply_of(m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[9:2], m_axis_tdata[10],
                   m_axis_tdata[18:11], m_axis_tuser, m_axis_tlast);
    if (awaited_replies.size() == 0) begin
      report("transfer with nothing awaited", int'(m_axis_tdata), 0);
      return;
    end
    want = awaited_replies.pop_front();
    if (got.rv !== want.rv) report("reply_valid", int'(got.rv), int'(want.rv));
    if (got.ack !== want.ack) report("reply_is_ack", int'(got.ack), int'(want.ack));
    if (got.seq !== want.seq) report("reply_seq", int'(got.seq), int'(want.seq));
    if (got.pv !== want.pv) report("payload_valid", int'(got.pv), int'(want.pv));
    if (got.pb !== want.pb) report("payload_byte", int'(got.pb), int'(want.pb));
    if (got.kind !== want.kind) report("frame_kind", int'(got.kind), int'(want.kind));
    if (got.last !== want.last) report("last", int'(got.last), int'(want.last));
  endtask

  task automatic offer(input logic cmd, input logic [7:0] data);
    bit took;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do begin
      @(negedge clk);
      took = s_axis_tready;
      @(posedge clk);
    end while (!took);
    predict_link(cmd, data);
  endtask

  task automatic push_item(input logic cmd, input logic [7:0] data);
    offer(cmd, data);
    foreach (step_replies[i]) awaited_replies.push_back(step_replies[i]);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_TIMEOUT) pr_timeout = val;
    else pr_max_len = val[6:0];
  endtask

  task automatic drain_to_idle(input bit swallow);
    if (swallow && pr_phase == LS_DISCARD) begin
      repeat ($urandom_range(0, 2)) push_item(CMD_BYTE, 8'($urandom_range(255)));
    end
    while (pr_phase != LS_IDLE) push_item(CMD_TICK, 8'($urandom_range(255)));
  endtask

  // now and then hold the line alive with up to three ticks short of the timeout, then send the byte
  task automatic send_link_byte(input logic [7:0] b);
    int most;
    most = (pr_timeout > 16'd3) ? 3 : int'(pr_timeout) - 1;
    if (most > 0 && $urandom_range(9) == 0) begin
      repeat ($urandom_range(1, most)) push_item(CMD_TICK, 8'($urandom_range(255)));
    end
    push_item(CMD_BYTE, b);
  endtask

  task automatic send_frame(input bit faults, input int force_len);
    int pick;
    int cut;
    int len;
    int i;
    logic [7:0]  ftype;
    logic [7:0]  fseq;
    logic [15:0] flen;
    pick = faults ? $urandom_range(99) : $urandom_range(69);
    if (force_len > 0) pick = 0;
    if (pick >= 92) begin
      repeat ($urandom_range(1, 3)) push_item(1'($urandom_range(1)), 8'($urandom_range(255)));
      drain_to_idle(1'b1);
      return;
    end
    case ($urandom_range(3))
      0: begin ftype = TYPE_BYTE;  flen = 16'd1; end
      1: begin ftype = TYPE_WORD;  flen = 16'd2; end
      2: begin ftype = TYPE_FLOAT; flen = 16'd4; end
      default: begin
        ftype = TYPE_DATA;
        len = (pr_max_len < 7'd8) ? int'(pr_max_len) : 8;
        len = ($urandom_range(9) == 0) ? int'(pr_max_len) : int'($urandom_range(1, len));
        flen = 16'(len);
      end
    endcase
    if (force_len > 0) begin
      ftype = TYPE_DATA;
      flen  = 16'(force_len);
    end
    fseq = (pick >= 60 && pick < 70 && pr_seen) ? pr_last_seq : 8'($urandom_range(255));
    if (pick >= 80 && pick < 86) begin
      do begin
        if ($urandom_range(1) == 0) ftype = 8'($urandom_range(255));
        else flen = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                             : 16'($urandom_range(70));
      end while (length_fits(ftype, flen));
    end
    send_link_byte(START_BYTE);
    send_link_byte(ftype);
    send_link_byte(fseq);
    send_link_byte(flen[15:8]);
    send_link_byte(flen[7:0]);
    if (pr_phase == LS_DISCARD) begin
      drain_to_idle(1'b1);
      return;
    end
    cut = (pick >= 86 && pick < 92) ? $urandom_range(0, flen) : int'(flen);
    for (i = 0; i < cut; i++) send_link_byte(8'($urandom_range(255)));
    if (pick >= 86 && pick < 92) begin
      drain_to_idle(1'b0);
      return;
    end
    if (pick >= 70 && pick < 80) send_link_byte(pr_crc ^ 8'($urandom_range(1, 255)));
    else send_link_byte(pr_crc);
    drain_to_idle(1'b1);
  endtask

  task automatic run_phase(input logic [15:0] tmo, input logic [6:0] mlen, input int s_pct,
                           input int r_pct, input int target, input bit faults,
                           input bit squeeze);
    int stop_at;
    settle();
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_MAX_LEN, {9'd0, mlen});
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    stop_at = live_items + target;
    if (squeeze) begin
      pressure_go = 1'b1;
      send_frame(1'b0, MAX_PAYLOAD);
    end
    while (live_items < stop_at) send_frame(faults, 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(negedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_reply();
  end

  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    stim_row_t row;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(REG_TIMEOUT, 16'd2);
    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      row = DIRECTED_ROWS[i];
      case (row.kind)
        ROW_TICK: offer(CMD_TICK, row.data);
        ROW_CRC:  offer(CMD_BYTE, pr_crc);
        default:  offer(CMD_BYTE, row.data);
      endcase
      if (row.typed) begin
        awaited_replies.push_back(row.want);
      end else begin
        foreach (step_replies[k]) awaited_replies.push_back(step_replies[k]);
      end
    end
    run_phase(16'd1, 7'd1, 36, 59, 90, 1'b1, 1'b0);
    run_phase(16'd5, 7'd58, 59, 36, 110, 1'b1, 1'b0);
    run_phase(16'hFFFF, 7'd64, 0, 0, 120, 1'b0, 1'b1);
    settle();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: framed_link_receiver_crc8_ack.f
rtl/flrx_pkg.sv
rtl/flrx_ctrl.sv
rtl/flrx_dp.sv
rtl/framed_link_receiver_crc8_ack.sv
verif/framed_link_receiver_crc8_ack_tb.sv
